### hdl/masked_byte_pattern_scanner_unit_macros.svh
// Assertion macros shared by the masked byte pattern scanner modules.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 64;
    localparam int PAT_W     = 128;
    localparam int CARE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 64;

    // Default pattern capacity in bytes
    localparam int MAX_PATTERN_DEF = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR    = 3'd4;

    // Register reset values
    localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;

    // Live configuration, length already clamped to the legal range
    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [CARE_W-1:0] care;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
    } cfg_t;

    // Control of the compare stage
    typedef struct packed {
        logic valid;
        logic last;
        logic full;
    } stage_t;

endpackage

`default_nettype wire

### hdl/mbps_cfg.sv
// Configuration registers of the masked byte pattern scanner.
// Depends on mbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mbps_pkg::CFG_DW-1:0]    cfg_wdata,
    output mbps_pkg::cfg_t                      cfg
);

    logic [63:0]                     pat_low_reg;
    logic [63:0]                     pat_high_reg;
    logic [mbps_pkg::CARE_W-1:0]     care_reg;
    logic [mbps_pkg::LEN_W-1:0]      len_reg;
    logic [mbps_pkg::ADDR_W-1:0]     base_reg;
    logic [mbps_pkg::LEN_W-1:0]      len_eff;

    // Write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= mbps_pkg::CARE_RESET;
            len_reg      <= mbps_pkg::LEN_RESET;
            base_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mbps_pkg::CFG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata;
                mbps_pkg::CFG_PATTERN_HIGH: pat_high_reg <= cfg_wdata;
                mbps_pkg::CFG_CARE_MASK:    care_reg     <= cfg_wdata[mbps_pkg::CARE_W-1:0];
                mbps_pkg::CFG_PATTERN_LEN:  len_reg      <= cfg_wdata[mbps_pkg::LEN_W-1:0];
                mbps_pkg::CFG_BASE_ADDR:    base_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp length: zero counts as one, cap at capacity
    always_comb begin
        if (len_reg == '0) begin
            len_eff = mbps_pkg::LEN_W'(1);
        end else if (len_reg > mbps_pkg::LEN_W'(MAX_PATTERN)) begin
            len_eff = mbps_pkg::LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = len_reg;
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.care    = care_reg;
    assign cfg.len     = len_eff;
    assign cfg.base    = base_reg;

endmodule

`default_nettype wire

### hdl/mbps_window.sv
// Input stage: byte window, fill count and byte position of the scanner.
// Depends on mbps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_byte_pattern_scanner_unit_macros.svh"

module mbps_window #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire mbps_pkg::cfg_t                    cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mbps_pkg::BYTE_W-1:0]       in_byte,
    input  wire logic                              in_first,
    input  wire logic                              in_last,
    input  wire logic                              stage_take,
    output mbps_pkg::stage_t                       stage,
    output logic [MAX_PATTERN*mbps_pkg::BYTE_W-1:0] win,
    output logic [mbps_pkg::ADDR_W-1:0]            start_ofs
);

    localparam int WIN_W = MAX_PATTERN * mbps_pkg::BYTE_W;

    logic [WIN_W-1:0]               win_reg;
    logic [WIN_W-1:0]               win_next;
    logic [mbps_pkg::LEN_W-1:0]     fill_reg;
    logic [mbps_pkg::LEN_W-1:0]     fill_cur;
    logic [mbps_pkg::LEN_W-1:0]     fill_new;
    logic [mbps_pkg::ADDR_W-1:0]    pos_reg;
    logic [mbps_pkg::ADDR_W-1:0]    pos_cur;
    logic [mbps_pkg::ADDR_W-1:0]    start_reg;
    logic [mbps_pkg::ADDR_W-1:0]    start_next;
    logic                           valid_reg;
    logic                           last_reg;
    logic                           full_reg;
    logic                           full_next;
    logic                           accept;

    assign in_ready = !valid_reg || stage_take;
    assign accept   = in_valid && in_ready;

    // Shift the new byte in at the newest end
    always_comb begin
        win_next[mbps_pkg::BYTE_W-1:0] = in_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_next[k*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W] =
                win_reg[(k-1)*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
        end
    end

    // Count, position and start offset of a match ending at this byte
    always_comb begin
        fill_cur   = in_first ? '0 : fill_reg;
        pos_cur    = in_first ? '0 : pos_reg;
        fill_new   = (fill_cur < mbps_pkg::LEN_W'(MAX_PATTERN))
                     ? fill_cur + mbps_pkg::LEN_W'(1) : fill_cur;
        full_next  = fill_new >= cfg.len;
        start_next = pos_cur - mbps_pkg::ADDR_W'(cfg.len - mbps_pkg::LEN_W'(1));
    end

    // Scan state: clear count and position after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end else if (accept) begin
            fill_reg <= in_last ? '0 : fill_new;
            pos_reg  <= in_last ? '0 : pos_cur + mbps_pkg::ADDR_W'(1);
        end
    end

    // Stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (stage_take) begin
            valid_reg <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg   <= win_next;
            start_reg <= start_next;
            last_reg  <= in_last;
            full_reg  <= full_next;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.last  = last_reg;
    assign stage.full  = full_reg;
    assign win         = win_reg;
    assign start_ofs   = start_reg;

    `MBPS_ASSERT_NEXT(a_end_clears, accept && in_last, fill_reg == '0 && pos_reg == '0, "scan state not cleared after last byte")
    `MBPS_ASSERT_NOW(a_fill_cap, 1'b1, fill_reg <= mbps_pkg::LEN_W'(MAX_PATTERN), "fill count above capacity")

endmodule

`default_nettype wire

### hdl/mbps_match.sv
// Masked window compare, match address and result register of the scanner.
// Depends on mbps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_byte_pattern_scanner_unit_macros.svh"

module mbps_match #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire mbps_pkg::cfg_t                     cfg,
    input  wire mbps_pkg::stage_t                   stage,
    input  wire logic [MAX_PATTERN*mbps_pkg::BYTE_W-1:0] win,
    input  wire logic [mbps_pkg::ADDR_W-1:0]        start_ofs,
    output logic                                    stage_take,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    out_found,
    output logic [mbps_pkg::ADDR_W-1:0]             out_addr,
    output logic                                    out_end
);

    logic [mbps_pkg::LEN_W-1:0]  diff [MAX_PATTERN];
    logic [mbps_pkg::BYTE_W-1:0] sel_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      hit;
    logic                        match;
    logic                        produce;
    logic                        load;
    logic                        valid_reg;
    logic                        found_reg;
    logic [mbps_pkg::ADDR_W-1:0] addr_reg;
    logic                        end_reg;

    // Pattern byte i lines up with the byte taken len-1-i steps ago
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            diff[i]     = cfg.len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
            sel_byte[i] = '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (diff[i] == mbps_pkg::LEN_W'(j)) begin
                    sel_byte[i] = win[j*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
                end
            end
            hit[i] = (mbps_pkg::LEN_W'(i) >= cfg.len) || !cfg.care[i] ||
                     (sel_byte[i] == cfg.pattern[i*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W]);
        end
    end

    assign match      = stage.full && (&hit);
    assign produce    = match || stage.last;
    assign load       = !valid_reg || out_ready;
    assign stage_take = stage.valid && (load || !produce);

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= stage.valid && produce;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            found_reg <= match;
            addr_reg  <= match ? cfg.base + start_ofs : '0;
            end_reg   <= stage.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_addr  = addr_reg;
    assign out_end   = end_reg;

    `MBPS_ASSERT_NOW(a_result_reason, valid_reg, found_reg || end_reg, "result without match or end")
    `MBPS_ASSERT_NOW(a_addr_zero, valid_reg && !found_reg, addr_reg == '0, "address set without match")
    `MBPS_ASSERT_NOW(a_no_early_match, stage.valid && !stage.full, !match, "match before window filled")

endmodule

`default_nettype wire

### hdl/masked_byte_pattern_scanner_unit.sv
// Channel  | Dir | Carries
// s_       | in  | tdata: data_byte; tuser: first_byte; tlast: last_byte
// m_       | out | tdata: match_address; tuser: match_found; tlast: scan_end
// cfg_     | in  | register index and data, one write per cycle
//
// One byte is accepted every cycle while the input is not stalled; a result leaves after
// its byte passes the window stage register and then the compare and result register.
// Bytes that end no match and are not last produce no transfer.
// A stalled result holds the compare stage; the input stalls only when both are full.
// Reset (aresetn low, synchronous) clears the scan state, valids and configuration registers.
// Top level of the masked byte pattern scanner. Depends on mbps_pkg,
// mbps_cfg, mbps_window and mbps_match.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration writes
    input  wire logic                           cfg_wr_en,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mbps_pkg::CFG_DW-1:0]    cfg_wdata,
    // byte stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tuser,   // [0] first_byte
    input  wire logic                           s_tlast,
    // match results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [63:0]                         m_tdata,   // [63:0] match_address
    output logic                                m_tuser,   // [0] match_found
    output logic                                m_tlast
);

    mbps_pkg::cfg_t                          cfg;
    mbps_pkg::stage_t                        stage;
    logic [MAX_PATTERN*mbps_pkg::BYTE_W-1:0] win;
    logic [mbps_pkg::ADDR_W-1:0]             start_ofs;
    logic                                    stage_take;

    mbps_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mbps_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_first   (s_tuser),
        .in_last    (s_tlast),
        .stage_take (stage_take),
        .stage      (stage),
        .win        (win),
        .start_ofs  (start_ofs)
    );

    mbps_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .stage      (stage),
        .win        (win),
        .start_ofs  (start_ofs),
        .stage_take (stage_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_found  (m_tuser),
        .out_addr   (m_tdata),
        .out_end    (m_tlast)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for masked_byte_pattern_scanner_unit.
// Drives haystack bytes and register writes, predicts every result transfer
// and checks it field by field; depends on mbps_pkg and the scanner RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int WIN_DEPTH   = 16;
    localparam int MAX_PAT     = mbps_pkg::MAX_PATTERN_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_PAUSE = 8;

    // Predicted content of one result transfer
    typedef struct {
        bit        found;
        bit [63:0] addr;
        bit        ends;
    } scan_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [mbps_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [mbps_pkg::CFG_DW-1:0]    cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           s_tuser;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [63:0]                    m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    // Predictor copy of the registers
    bit [63:0]                 pat_lo_q;
    bit [63:0]                 pat_hi_q;
    bit [mbps_pkg::CARE_W-1:0] care_q;
    bit [mbps_pkg::LEN_W-1:0]  len_q;
    bit [63:0]                 base_q;

    // Predictor copy of the scan state
    bit [7:0]         hay_window [WIN_DEPTH];
    int unsigned      hay_fill;
    bit [63:0]        hay_pos;

    scan_result_t     pending_hits [$];
    int unsigned      mismatch_count;
    int unsigned      quiet_cycles;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;

    masked_byte_pattern_scanner_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tuser   (s_tuser),   // [0] first_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [63:0] match_address
        .m_tuser   (m_tuser),   // [0] match_found
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Clamp the programmed length to 1..MAX_PAT
    function automatic int unsigned active_length();
        int unsigned n;
        n = len_q;
        if (n == 0) n = 1;
        if (n > MAX_PAT) n = MAX_PAT;
        return n;
    endfunction

    function automatic bit [7:0] pattern_byte_at(int unsigned i);
        bit [127:0] pat;
        pat = {pat_hi_q, pat_lo_q};
        return pat[8*i +: 8];
    endfunction

    // Advance the scan state by one byte and queue the result it causes
    function automatic void score_byte(bit [7:0] data, bit first, bit last);
        int unsigned  n;
        bit           hit;
        bit [63:0]    here;
        scan_result_t res;
        n = active_length();
        if (first) begin
            foreach (hay_window[k]) hay_window[k] = 8'h00;
            hay_fill = 0;
            hay_pos  = '0;
        end
        for (int k = WIN_DEPTH - 1; k > 0; k--) hay_window[k] = hay_window[k-1];
        hay_window[0] = data;
        if (hay_fill < MAX_PAT) hay_fill++;
        here    = hay_pos;
        hay_pos = hay_pos + 64'd1;
        hit = 1'b0;
        if (hay_fill >= n) begin
            hit = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (care_q[i] && hay_window[n-1-i] != pattern_byte_at(i)) hit = 1'b0;
            end
        end
        if (last) begin
            hay_fill = 0;
            hay_pos  = '0;
        end
        if (hit || last) begin
            res.found = hit;
            res.addr  = hit ? base_q + (here - 64'(n - 1)) : 64'd0;
            res.ends  = last;
            pending_hits.push_back(res);
        end
    endfunction

    function automatic void apply_register(logic [mbps_pkg::CFG_IDX_W-1:0] idx,
                                           bit [63:0] val);
        case (idx)
            mbps_pkg::CFG_PATTERN_LOW:  pat_lo_q = val;
            mbps_pkg::CFG_PATTERN_HIGH: pat_hi_q = val;
            mbps_pkg::CFG_CARE_MASK:    care_q   = val[mbps_pkg::CARE_W-1:0];
            mbps_pkg::CFG_PATTERN_LEN:  len_q    = val[mbps_pkg::LEN_W-1:0];
            mbps_pkg::CFG_BASE_ADDR:    base_q   = val;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Write all five registers, one per cycle; called at a falling edge
    task automatic load_config(bit [63:0] plo, bit [63:0] phi, bit [63:0] care,
                               bit [63:0] len, bit [63:0] base);
        logic [mbps_pkg::CFG_IDX_W-1:0] idx [5];
        bit [63:0]                      val [5];
        idx = '{mbps_pkg::CFG_PATTERN_LOW, mbps_pkg::CFG_PATTERN_HIGH,
                mbps_pkg::CFG_CARE_MASK, mbps_pkg::CFG_PATTERN_LEN,
                mbps_pkg::CFG_BASE_ADDR};
        val = '{plo, phi, care, len, base};
        for (int r = 0; r < 5; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[r];
            cfg_wdata <= val[r];
            @(posedge aclk);
            apply_register(idx[r], val[r]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Send one byte, with a random lead-in gap; returns at a falling edge
    task automatic send_byte(bit [7:0] data, bit first, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        score_byte(data, first, last);
        @(negedge aclk);
    endtask

    // Drop valid, let every predicted result arrive, then let the pipe empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register values after reset: pattern zero, length one, so zero bytes hit
    task automatic test_reset_config();
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        drain_results();
    endtask

    // Length zero acts as one; length above the maximum acts as the maximum
    task automatic test_length_clamp();
        load_config(64'hFF, 64'h0, 64'hFFFF, 64'd0, 64'h1000);
        send_byte(8'hFF, 1'b1, 1'b1);
        drain_results();
        load_config('1, '1, 64'h0, 64'd31, 64'h0);
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b1);
        drain_results();
    endtask

    // Overlapping hits at a base that makes the address wrap
    task automatic test_overlap_wrap();
        load_config(64'hAAAA, 64'h0, 64'h3, 64'd2, '1);
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        drain_results();
    endtask

    // Care bits past the length are ignored; a short haystack ends without a hit
    task automatic test_care_past_length();
        load_config(64'h0000_0000_0033_2211, {$urandom, $urandom}, 64'hFFFF, 64'd3,
                    64'h8000_0000_0000_0000);
        send_byte(8'h11, 1'b0, 1'b0);
        send_byte(8'h22, 1'b0, 1'b0);
        send_byte(8'h33, 1'b0, 1'b1);
        send_byte(8'h11, 1'b0, 1'b0);
        send_byte(8'h22, 1'b0, 1'b1);
        drain_results();
    endtask

    // Ten-byte pattern reaching into the high word, with wildcard bytes
    task automatic test_long_wildcard();
        bit [7:0] b;
        load_config({$urandom, $urandom}, {$urandom, $urandom}, 64'hFC35, 64'd10,
                    {$urandom, $urandom});
        for (int i = 0; i < 10; i++) begin
            b = care_q[i] ? pattern_byte_at(i) : 8'($urandom);
            send_byte(b, i == 0, i == 9);
        end
        drain_results();
    endtask

    // Random settings and haystacks, mostly seeded with the pattern
    task automatic test_random_scan(int unsigned count, int unsigned sp, int unsigned rp);
        int unsigned sent;
        int unsigned seg;
        int unsigned n;
        int unsigned hlen;
        int unsigned off;
        bit          first_on;
        bit          last_on;
        bit [63:0]   plo;
        bit [63:0]   phi;
        bit [63:0]   care;
        bit [63:0]   len;
        bit [63:0]   base;
        bit [7:0]    hay [24];
        send_idle_pct = sp;
        recv_idle_pct = rp;
        sent = 0;
        while (sent < count) begin
            drain_results();
            plo = {$urandom, $urandom};
            phi = {$urandom, $urandom};
            case ($urandom_range(7))
                0: begin plo = '0; phi = '0; end
                1: begin plo = '1; phi = '1; end
                default: ;
            endcase
            case ($urandom_range(5))
                0:       care = 64'hFFFF;
                1:       care = 64'h0;
                2:       care = {$urandom, $urandom};
                default: care = 64'($urandom | $urandom);
            endcase
            case ($urandom_range(7))
                0:       len = 64'd1;
                1:       len = 64'd16;
                2:       len = 64'd0;
                3:       len = 64'($urandom_range(17, 31));
                4:       len = 64'($urandom_range(7, 15));
                default: len = 64'($urandom_range(2, 6));
            endcase
            case ($urandom_range(5))
                0:       base = '0;
                1:       base = '1;
                2:       base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20));
                default: base = {$urandom, $urandom};
            endcase
            load_config(plo, phi, care, len, base);
            n = active_length();
            seg = $urandom_range(20, 60);
            while (seg > 0 && sent < count) begin
                hlen = $urandom_range(1, 24);
                for (int j = 0; j < hlen; j++) begin
                    hay[j] = $urandom_range(1) ? pattern_byte_at($urandom_range(0, n - 1))
                                               : 8'($urandom);
                end
                // Plant the pattern, wildcards left random
                if (hlen >= n && $urandom_range(2) != 0) begin
                    off = $urandom_range(0, hlen - n);
                    for (int i = 0; i < n; i++) begin
                        if (care_q[i] || $urandom_range(1)) hay[off+i] = pattern_byte_at(i);
                    end
                end
                first_on = ($urandom_range(3) != 0);
                last_on  = ($urandom_range(7) != 0);
                for (int j = 0; j < hlen; j++) begin
                    send_byte(hay[j], first_on && j == 0, last_on && j == hlen - 1);
                end
                sent += hlen;
                seg = (seg > hlen) ? seg - hlen : 0;
            end
        end
        drain_results();
    endtask

    // Result checker: compare every transfer with the oldest prediction
    always @(posedge aclk) begin
        scan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unpredicted transfer", m_tdata, 64'd0);
            end else begin
                want = pending_hits.pop_front();
                if (m_tuser !== want.found) begin
                    report_mismatch("match_found", 64'(m_tuser), 64'(want.found));
                end
                if (m_tdata !== want.addr) begin
                    report_mismatch("match_address", m_tdata, want.addr);
                end
                if (m_tlast !== want.ends) begin
                    report_mismatch("scan_end", 64'(m_tlast), 64'(want.ends));
                end
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("masked_byte_pattern_scanner_unit test failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 37;
        recv_idle_pct  = 64;
        pat_lo_q       = '0;
        pat_hi_q       = '0;
        care_q         = mbps_pkg::CARE_RESET;
        len_q          = mbps_pkg::LEN_RESET;
        base_q         = '0;
        foreach (hay_window[k]) hay_window[k] = 8'h00;
        hay_fill       = 0;
        hay_pos        = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_config();
        test_length_clamp();
        test_overlap_wrap();
        test_care_past_length();
        test_long_wildcard();
        test_random_scan(250, 37, 64);
        test_random_scan(250, 64, 37);
        test_random_scan(250, 0, 0);

        drain_results();
        if (mismatch_count == 0) begin
            $display("masked_byte_pattern_scanner_unit test passed");
        end else begin
            $display("masked_byte_pattern_scanner_unit test failed");
        end
        $finish;
    end

endmodule
